// File: design/tspd_pkg.sv
// shared constants, payload types and the duty scaling function
`default_nettype none

package tspd_pkg;

  // sizes
  localparam int ECHO_BITS  = 20;
  localparam int TIMER_BITS = 13;
  localparam int MS_BITS    = 12;
  localparam int LIMIT_BITS = 9;
  localparam int DUTY_BITS  = 8;
  localparam int LINE_BITS  = 4;
  localparam int MODE_BITS  = 3;
  localparam int NUM_REGS   = 4;
  localparam int APB_DATA_W = 32;
  localparam int ADDR_W     = $clog2(NUM_REGS * 4);

  // distance scaling: cm = echo * 348 / 20000
  localparam int unsigned SOUND_CM_PER_S = 34800;
  localparam int unsigned US_PER_S       = 1000000;
  localparam int unsigned ECHO_SCALE     = SOUND_CM_PER_S / 100;
  localparam int unsigned CM_DIVISOR     = 2 * US_PER_S / 100;
  localparam int unsigned FAR_CM         = 100;
  localparam int unsigned CLOSE_CM       = 3;
  localparam int unsigned FULL_DUTY      = 255;
  localparam int unsigned FAR_SCALED     = FAR_CM * CM_DIVISOR;
  localparam int          CM_W           = $clog2(FAR_CM);

  // cm = ((scaled >> 5) / 625) via reciprocal multiply, exact for 16-bit operands
  localparam int          CM_PRE_SHIFT   = 5;
  localparam int unsigned CM_ODD         = CM_DIVISOR >> CM_PRE_SHIFT;
  localparam int          CM_U_W         = 16;
  localparam int          CM_RECIP_SHIFT = 26;
  localparam int unsigned CM_RECIP       = ((1 << CM_RECIP_SHIFT) + CM_ODD - 1) / CM_ODD;
  localparam int          CM_PROD_W      = CM_U_W + $clog2(CM_RECIP + 1);

  // (100 - cm) * 255 / 97 via reciprocal multiply
  localparam int unsigned DUTY_DIV   = FAR_CM - CLOSE_CM;
  localparam int          DUTY_SHIFT = 22;
  localparam int unsigned DUTY_RECIP = ((1 << DUTY_SHIFT) + DUTY_DIV - 1) / DUTY_DIV;
  localparam int          DUTY_X_W   = CM_W + DUTY_BITS;
  localparam int          DUTY_Y_W   = 31;

  // widths of products and compares
  localparam int PROD_W  = ECHO_BITS + 9;
  localparam int SCALE_W = 24;
  localparam int NEAR_W  = (PROD_W > SCALE_W) ? PROD_W : SCALE_W;
  localparam int CMP_W   = (TIMER_BITS > MS_BITS) ? TIMER_BITS : MS_BITS;
  localparam int SUM_W   = CMP_W + 1;

  // register reset values
  localparam logic [LIMIT_BITS-1:0] NEAR_LIMIT_RESET = LIMIT_BITS'(100);
  localparam logic [DUTY_BITS-1:0]  SPIN_DUTY_RESET  = DUTY_BITS'(128);
  localparam logic [MS_BITS-1:0]    WAIT_MS_RESET    = MS_BITS'(1000);
  localparam logic [MS_BITS-1:0]    SPIN_MS_RESET    = MS_BITS'(1000);

  // register indexes
  typedef enum logic [ADDR_W-3:0] {
    REG_NEAR_LIMIT,
    REG_SPIN_DUTY,
    REG_WAIT_MS,
    REG_SPIN_MS
  } reg_idx_e;

  // bridge direction lines
  localparam logic [LINE_BITS-1:0] LINE_E1 = 4'b0001;
  localparam logic [LINE_BITS-1:0] LINE_E2 = 4'b0010;
  localparam logic [LINE_BITS-1:0] LINE_E3 = 4'b0100;
  localparam logic [LINE_BITS-1:0] LINE_E4 = 4'b1000;

  // reported modes
  localparam logic [MODE_BITS-1:0] MODE_IDLE       = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_TRACKING   = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_WAITING    = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_SPIN_RIGHT = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_SPIN_LEFT  = 3'd4;

  typedef struct packed {
    logic [ECHO_BITS-1:0] echo_left_us;
    logic [ECHO_BITS-1:0] echo_centre_us;
    logic [ECHO_BITS-1:0] echo_right_us;
    logic                 button_level;
    logic [MS_BITS-1:0]   elapsed_ms;
  } sweep_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] motor_one_duty;
    logic [DUTY_BITS-1:0] motor_two_duty;
    logic [LINE_BITS-1:0] bridge_lines;
    logic                 enabled;
    logic [MODE_BITS-1:0] mode_report;
  } drive_t;

  typedef struct packed {
    logic [SCALE_W-1:0]   near_scaled;
    logic [DUTY_BITS-1:0] spin_duty;
    logic [MS_BITS-1:0]   wait_ms;
    logic [MS_BITS-1:0]   spin_ms;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [ECHO_BITS-1:0] echo;
  } dist_cmd_t;

  typedef struct packed {
    logic                 done;
    logic                 near;
    logic [DUTY_BITS-1:0] duty;
  } dist_res_t;

  // duty for a distance below the far limit, saturated at full duty
  function automatic logic [DUTY_BITS-1:0] duty_of_cm(input logic [CM_W-1:0] cm);
    logic [CM_W-1:0]     n;
    logic [DUTY_X_W-1:0] x;
    logic [DUTY_Y_W-1:0] y;
    logic [DUTY_BITS:0]  q;
    n = CM_W'(FAR_CM) - cm;
    x = {n, {DUTY_BITS{1'b0}}} - DUTY_X_W'(n);
    y = DUTY_Y_W'(x) * DUTY_Y_W'(DUTY_RECIP);
    q = y[DUTY_SHIFT +: DUTY_BITS + 1];
    return (q > (DUTY_BITS + 1)'(FULL_DUTY)) ? DUTY_BITS'(FULL_DUTY) : q[DUTY_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// File: design/tspd_if.sv
// valid/ready channel interfaces for sweep and drive words
`default_nettype none

interface tspd_sweep_if import tspd_pkg::*; ();
  logic   valid;
  logic   ready;
  sweep_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tspd_drive_if import tspd_pkg::*; ();
  logic   valid;
  logic   ready;
  drive_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/tspd_regs.sv
// apb configuration registers with pre-scaled near limit
`default_nettype none

module tspd_regs import tspd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [LIMIT_BITS-1:0] near_limit_q;
  logic [SCALE_W-1:0]    near_scaled_q;
  logic [DUTY_BITS-1:0]  spin_duty_q;
  logic [MS_BITS-1:0]    wait_ms_q;
  logic [MS_BITS-1:0]    spin_ms_q;
  logic                  wr_en;
  reg_idx_e              idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_limit_q  <= NEAR_LIMIT_RESET;
      near_scaled_q <= SCALE_W'(NEAR_LIMIT_RESET) * SCALE_W'(CM_DIVISOR);
      spin_duty_q   <= SPIN_DUTY_RESET;
      wait_ms_q     <= WAIT_MS_RESET;
      spin_ms_q     <= SPIN_MS_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_NEAR_LIMIT: begin
          near_limit_q  <= pwdata[LIMIT_BITS-1:0];
          // limit in echo units, so the nearness test is a plain compare
          near_scaled_q <= SCALE_W'(pwdata[LIMIT_BITS-1:0]) * SCALE_W'(CM_DIVISOR);
        end
        REG_SPIN_DUTY: spin_duty_q <= pwdata[DUTY_BITS-1:0];
        REG_WAIT_MS:   wait_ms_q   <= pwdata[MS_BITS-1:0];
        REG_SPIN_MS:   spin_ms_q   <= pwdata[MS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NEAR_LIMIT: prdata = APB_DATA_W'(near_limit_q);
      REG_SPIN_DUTY:  prdata = APB_DATA_W'(spin_duty_q);
      REG_WAIT_MS:    prdata = APB_DATA_W'(wait_ms_q);
      REG_SPIN_MS:    prdata = APB_DATA_W'(spin_ms_q);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = '{near_scaled: near_scaled_q, spin_duty: spin_duty_q,
                   wait_ms: wait_ms_q, spin_ms: spin_ms_q};

endmodule

`default_nettype wire

// File: design/tspd_dist.sv
// shared distance unit: scale, nearness compare, reciprocal divide, duty
`default_nettype none

module tspd_dist import tspd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dist_cmd_t          cmd_i,
  input  logic [SCALE_W-1:0] near_scaled_i,
  output dist_res_t          res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CMP,
    S_DIV,
    S_SCALE
  } state_e;

  state_e               state_q;
  logic [ECHO_BITS-1:0] echo_q;
  logic [PROD_W-1:0]    rem_q;
  logic [CM_W-1:0]      quot_q;
  logic                 near_q;
  logic                 far_q;
  logic [DUTY_BITS-1:0] duty_q;
  logic                 done_q;
  logic [CM_PROD_W-1:0] cm_prod;

  // only meaningful below the far limit, where the scaled echo fits 21 bits
  assign cm_prod = CM_PROD_W'(rem_q[CM_PRE_SHIFT +: CM_U_W]) * CM_PROD_W'(CM_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == S_SCALE);
      case (state_q)
        S_IDLE: begin
          if (cmd_i.start) begin
            echo_q  <= cmd_i.echo;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          rem_q   <= PROD_W'(echo_q) * PROD_W'(ECHO_SCALE);
          state_q <= S_CMP;
        end
        S_CMP: begin
          near_q  <= NEAR_W'(rem_q) <= NEAR_W'(near_scaled_i);
          far_q   <= rem_q >= PROD_W'(FAR_SCALED);
          state_q <= S_DIV;
        end
        S_DIV: begin
          quot_q  <= cm_prod[CM_RECIP_SHIFT +: CM_W];
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          duty_q  <= far_q ? '0 : duty_of_cm(quot_q);
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o = '{done: done_q, near: near_q, duty: duty_q};

endmodule

`default_nettype wire

// File: design/tspd_ctrl.sv
// sweep sequencer, pursuit and patrol decisions, output word register
`default_nettype none

module tspd_ctrl import tspd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  tspd_sweep_if.sink   sweep_i,
  tspd_drive_if.source drive_o,
  input  cfg_t         cfg_i,
  output dist_cmd_t    dist_cmd_o,
  input  dist_res_t    dist_res_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_DECIDE
  } state_e;

  typedef enum logic [1:0] {
    SIDE_LEFT,
    SIDE_CENTRE,
    SIDE_RIGHT
  } side_e;

  typedef enum logic [1:0] {
    ENG_NONE,
    ENG_ENGAGED,
    ENG_PATROL
  } engage_e;

  typedef enum logic [1:0] {
    PAT_NONE,
    PAT_WAIT,
    PAT_RIGHT,
    PAT_LEFT
  } patrol_e;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  state_e                         state_q;
  side_e                          side_q;
  logic                           start_q;
  sweep_t                         in_q;
  logic [2:0]                     near_q;
  logic [2:0][DUTY_BITS-1:0]      duty_q;
  logic                           out_valid_q;
  drive_t                         out_q;

  logic                           allowed_q, allowed_d;
  logic                           seen_q, seen_d;
  engage_e                        engage_q, engage_d;
  patrol_e                        patrol_q, patrol_d;
  logic [TIMER_BITS-1:0]          timer_q, timer_d;
  logic [DUTY_BITS-1:0]           held_one_q, held_one_d;
  logic [DUTY_BITS-1:0]           held_two_q, held_two_d;
  logic [LINE_BITS-1:0]           held_lines_q, held_lines_d;
  logic [MODE_BITS-1:0]           mode_d;
  drive_t                         out_d;

  logic                           nl, nc, nr;
  logic [DUTY_BITS-1:0]           dl, dc, dr;
  logic [SUM_W-1:0]               sum;
  logic [TIMER_BITS-1:0]          timer_sat;
  logic                           entering;
  logic                           wait_over, spin_over;
  logic                           out_free;

  assign sweep_i.ready = (state_q == S_IDLE);
  assign drive_o.valid = out_valid_q;
  assign drive_o.data  = out_q;
  assign out_free      = !out_valid_q || drive_o.ready;

  always_comb begin
    case (side_q)
      SIDE_LEFT:   dist_cmd_o.echo = in_q.echo_left_us;
      SIDE_CENTRE: dist_cmd_o.echo = in_q.echo_centre_us;
      default:     dist_cmd_o.echo = in_q.echo_right_us;
    endcase
    dist_cmd_o.start = start_q;
  end

  assign nl = near_q[SIDE_LEFT];
  assign nc = near_q[SIDE_CENTRE];
  assign nr = near_q[SIDE_RIGHT];
  assign dl = duty_q[SIDE_LEFT];
  assign dc = duty_q[SIDE_CENTRE];
  assign dr = duty_q[SIDE_RIGHT];

  // phase timer advance, saturating
  assign sum       = SUM_W'(timer_q) + SUM_W'(in_q.elapsed_ms);
  assign timer_sat = (sum > SUM_W'(TIMER_MAX)) ? TIMER_MAX : sum[TIMER_BITS-1:0];
  assign wait_over = CMP_W'(timer_sat) > CMP_W'(cfg_i.wait_ms);
  assign spin_over = CMP_W'(timer_sat) > CMP_W'(cfg_i.spin_ms);

  always_comb begin
    engage_d     = engage_q;
    patrol_d     = patrol_q;
    timer_d      = timer_q;
    held_one_d   = held_one_q;
    held_two_d   = held_two_q;
    held_lines_d = held_lines_q;
    mode_d       = MODE_IDLE;
    allowed_d    = allowed_q;
    seen_d       = seen_q;
    entering     = 1'b0;

    if (!allowed_q) begin
      held_one_d   = '0;
      held_two_d   = '0;
      held_lines_d = '0;
      patrol_d     = PAT_NONE;
      timer_d      = '0;
    end else if (nl || nc || nr) begin
      patrol_d = PAT_NONE;
      timer_d  = '0;
      mode_d   = MODE_TRACKING;
      if (nl && !nc && !nr) begin
        held_one_d   = dl;
        held_two_d   = dl;
        held_lines_d = LINE_E1 | LINE_E3;
        engage_d     = ENG_ENGAGED;
      end else if (nl && nc && !nr) begin
        held_one_d   = '0;
        held_two_d   = (in_q.echo_left_us <= in_q.echo_centre_us) ? dl : dc;
        held_lines_d = LINE_E3;
        engage_d     = ENG_ENGAGED;
      end else if (!nl && !nc && nr) begin
        held_one_d   = dr;
        held_two_d   = dr;
        held_lines_d = LINE_E2 | LINE_E4;
        engage_d     = ENG_ENGAGED;
      end else if (!nl && nc && nr) begin
        held_one_d   = (in_q.echo_centre_us <= in_q.echo_right_us) ? dc : dr;
        held_two_d   = '0;
        held_lines_d = LINE_E2;
        engage_d     = ENG_ENGAGED;
      end else if (!nl && nc && !nr) begin
        held_one_d   = dc;
        held_two_d   = dc;
        held_lines_d = LINE_E2 | LINE_E3;
        engage_d     = ENG_ENGAGED;
      end
      // left and right together: outputs held
    end else if (engage_q != ENG_NONE) begin
      if (engage_q == ENG_ENGAGED) begin
        entering = (patrol_q != PAT_WAIT);
      end else begin
        entering = (patrol_q != PAT_RIGHT) && (patrol_q != PAT_LEFT);
      end
      if (entering) begin
        patrol_d = (engage_q == ENG_ENGAGED) ? PAT_WAIT : PAT_RIGHT;
        timer_d  = '0;
      end else begin
        timer_d = timer_sat;
        if (patrol_q == PAT_WAIT && wait_over) begin
          engage_d = ENG_PATROL;
          patrol_d = PAT_RIGHT;
          timer_d  = '0;
        end else if (patrol_q == PAT_RIGHT && spin_over) begin
          patrol_d = PAT_LEFT;
          timer_d  = '0;
        end else if (patrol_q == PAT_LEFT && spin_over) begin
          patrol_d = PAT_RIGHT;
          timer_d  = '0;
        end
      end
      case (patrol_d)
        PAT_WAIT: begin
          held_one_d   = '0;
          held_two_d   = '0;
          held_lines_d = '0;
          mode_d       = MODE_WAITING;
        end
        PAT_RIGHT: begin
          held_one_d   = cfg_i.spin_duty;
          held_two_d   = cfg_i.spin_duty;
          held_lines_d = LINE_E2 | LINE_E4;
          mode_d       = MODE_SPIN_RIGHT;
        end
        default: begin
          held_one_d   = cfg_i.spin_duty;
          held_two_d   = cfg_i.spin_duty;
          held_lines_d = LINE_E1 | LINE_E3;
          mode_d       = MODE_SPIN_LEFT;
        end
      endcase
    end

    // button acts on the next sweep
    if (in_q.button_level) begin
      seen_d = 1'b1;
    end else if (seen_q) begin
      seen_d    = 1'b0;
      allowed_d = !allowed_q;
    end

    out_d = '{motor_one_duty: held_one_d, motor_two_duty: held_two_d,
              bridge_lines: held_lines_d, enabled: allowed_q, mode_report: mode_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      side_q       <= SIDE_LEFT;
      start_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      allowed_q    <= 1'b1;
      seen_q       <= 1'b0;
      engage_q     <= ENG_NONE;
      patrol_q     <= PAT_NONE;
      timer_q      <= '0;
      held_one_q   <= '0;
      held_two_q   <= '0;
      held_lines_q <= '0;
    end else begin
      // a new word may replace the one being taken in the same cycle
      if (state_q == S_DECIDE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && drive_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          start_q <= sweep_i.valid;
          if (sweep_i.valid) begin
            in_q    <= sweep_i.data;
            side_q  <= SIDE_LEFT;
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          start_q <= dist_res_i.done && (side_q != SIDE_RIGHT);
          if (dist_res_i.done) begin
            near_q[side_q] <= dist_res_i.near;
            duty_q[side_q] <= dist_res_i.duty;
            case (side_q)
              SIDE_LEFT:   side_q  <= SIDE_CENTRE;
              SIDE_CENTRE: side_q  <= SIDE_RIGHT;
              default:     state_q <= S_DECIDE;
            endcase
          end
        end
        S_DECIDE: begin
          start_q <= 1'b0;
          if (out_free) begin
            out_q        <= out_d;
            allowed_q    <= allowed_d;
            seen_q       <= seen_d;
            engage_q     <= engage_d;
            patrol_q     <= patrol_d;
            timer_q      <= timer_d;
            held_one_q   <= held_one_d;
            held_two_q   <= held_two_d;
            held_lines_q <= held_lines_d;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          start_q <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/three_sensor_pursuit_drive.sv
// three-sensor pursuit drive: top level
//
//   channel   dir   handshake           word
//   sweep_i   in    valid/ready         three echo widths, button level, elapsed ms
//   drive_o   out   valid/ready         two motor duties, bridge lines, enable, mode
//   apb       in    psel/penable/pready near limit, spin duty, wait ms, spin ms
//
// in one sweep the three echoes pass one after another through the shared
// distance unit, each through the steps start, scale multiply, compare,
// reciprocal divide, duty and done, then a decision step forms the result
// word; sweep_i is ready again the cycle after the decision, so the block
// takes no new sweep before it is through with the last one
// reset is asynchronous and active low; registers return to their defaults
// sweep_i is ready only between sweeps; a result waiting on drive_o does not
// stop the next sweep from being taken, only its own decision step
`default_nettype none

module three_sensor_pursuit_drive import tspd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tspd_sweep_if.sink            sweep_i,
  tspd_drive_if.source          drive_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t      cfg;
  dist_cmd_t dist_cmd;
  dist_res_t dist_res;

  // configuration registers; the near limit is kept pre-multiplied into
  // echo units so nearness needs no division
  tspd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // one distance unit shared by left, centre and right in turn
  tspd_dist u_dist (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dist_cmd),
    .near_scaled_i (cfg.near_scaled),
    .res_o         (dist_res)
  );

  // sequencer, pursuit and patrol state, result register
  tspd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sweep_i    (sweep_i),
    .drive_o    (drive_o),
    .cfg_i      (cfg),
    .dist_cmd_o (dist_cmd),
    .dist_res_i (dist_res)
  );

endmodule

`default_nettype wire

// File: test/tb.sv
// testbench for the three-sensor pursuit drive: directed and random sweeps with a local predictor
`timescale 1ns / 1ps

module tb;
  import tspd_pkg::*;

  // distance in cm is echo * 348 / 20000, computed exactly here
  localparam longint unsigned CM_NUM = 348;
  localparam longint unsigned CM_DEN = 20000;
  localparam int unsigned ECHO_TOP = 1000000;
  localparam int unsigned MS_TOP = 4095;
  localparam logic [TIMER_BITS-1:0] PHASE_MAX = '1;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_SWEEPS = 110;

  // near flags packed as {left, centre, right}
  localparam logic [2:0] SEE_NONE = 3'b000;
  localparam logic [2:0] SEE_R = 3'b001;
  localparam logic [2:0] SEE_C = 3'b010;
  localparam logic [2:0] SEE_CR = 3'b011;
  localparam logic [2:0] SEE_L = 3'b100;
  localparam logic [2:0] SEE_LR = 3'b101;
  localparam logic [2:0] SEE_LC = 3'b110;
  localparam logic [2:0] SEE_ALL = 3'b111;

  typedef enum logic [1:0] {ENG_NEVER, ENG_TRACKED, ENG_PATROL} engage_e;
  typedef enum logic [1:0] {PATROL_OFF, PATROL_WAIT, PATROL_RIGHT, PATROL_LEFT} patrol_e;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  tspd_sweep_if sweep_if ();
  tspd_drive_if drive_if ();

  three_sensor_pursuit_drive dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .sweep_i (sweep_if),
    .drive_o (drive_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // register copies used by the predictor
  logic [LIMIT_BITS-1:0] cfg_near_cm;
  logic [DUTY_BITS-1:0] cfg_spin_duty;
  logic [MS_BITS-1:0] cfg_wait_ms;
  logic [MS_BITS-1:0] cfg_spin_ms;

  // predicted block state
  logic allow_drive;
  logic button_down;
  engage_e engage_state;
  patrol_e patrol_state;
  logic [TIMER_BITS-1:0] phase_ms;
  logic [DUTY_BITS-1:0] hold_one;
  logic [DUTY_BITS-1:0] hold_two;
  logic [LINE_BITS-1:0] hold_lines;

  drive_t pending_drive_words[$];
  int errors;
  int sweeps_sent;
  int words_checked;
  int settings_used;
  int mode_seen[5];
  int burst_left;

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #(5_000_000);
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // exact nearness test against the configured limit
  function automatic logic sees_target(logic [ECHO_BITS-1:0] echo);
    return 64'(echo) * CM_NUM <= 64'(cfg_near_cm) * CM_DEN;
  endfunction

  // whole-cm distance mapped to duty: 255 at 3 cm or closer, 0 at 100 cm and beyond
  function automatic logic [DUTY_BITS-1:0] echo_duty(logic [ECHO_BITS-1:0] echo);
    longint unsigned cm;
    longint unsigned d;
    cm = 64'(echo) * CM_NUM / CM_DEN;
    if (cm >= 100) return '0;
    d = (100 - cm) * 255 / 97;
    return (d > 255) ? 8'd255 : DUTY_BITS'(d);
  endfunction

  function automatic void set_hold(logic [DUTY_BITS-1:0] d1, logic [DUTY_BITS-1:0] d2,
                                   logic [LINE_BITS-1:0] lines);
    hold_one = d1;
    hold_two = d2;
    hold_lines = lines;
  endfunction

  // one sweep in, one drive word out; updates the predicted state
  function automatic drive_t predict_drive(sweep_t s);
    drive_t w;
    logic nl, nc, nr, entering;
    logic [DUTY_BITS-1:0] dl, dc, dr;
    logic [TIMER_BITS:0] sum;
    logic [MODE_BITS-1:0] mode;
    mode = MODE_IDLE;
    w.enabled = allow_drive;
    if (!allow_drive) begin
      // disabled: motors off, patrol dropped, engagement remembered
      set_hold('0, '0, '0);
      patrol_state = PATROL_OFF;
      phase_ms = '0;
    end else begin
      nl = sees_target(s.echo_left_us);
      nc = sees_target(s.echo_centre_us);
      nr = sees_target(s.echo_right_us);
      dl = echo_duty(s.echo_left_us);
      dc = echo_duty(s.echo_centre_us);
      dr = echo_duty(s.echo_right_us);
      if (nl || nc || nr) begin
        patrol_state = PATROL_OFF;
        phase_ms = '0;
        mode = MODE_TRACKING;
        case ({nl, nc, nr})
          SEE_L: begin
            set_hold(dl, dl, LINE_E1 | LINE_E3);
            engage_state = ENG_TRACKED;
          end
          SEE_LC: begin
            set_hold('0, (s.echo_left_us <= s.echo_centre_us) ? dl : dc, LINE_E3);
            engage_state = ENG_TRACKED;
          end
          SEE_R: begin
            set_hold(dr, dr, LINE_E2 | LINE_E4);
            engage_state = ENG_TRACKED;
          end
          SEE_CR: begin
            set_hold((s.echo_centre_us <= s.echo_right_us) ? dc : dr, '0, LINE_E2);
            engage_state = ENG_TRACKED;
          end
          SEE_C: begin
            set_hold(dc, dc, LINE_E2 | LINE_E3);
            engage_state = ENG_TRACKED;
          end
          default: ;  // left and right together: outputs held
        endcase
      end else if (engage_state != ENG_NEVER) begin
        if (engage_state == ENG_TRACKED) entering = (patrol_state != PATROL_WAIT);
        else entering = !(patrol_state == PATROL_RIGHT || patrol_state == PATROL_LEFT);
        if (entering) begin
          patrol_state = (engage_state == ENG_TRACKED) ? PATROL_WAIT : PATROL_RIGHT;
          phase_ms = '0;
        end else begin
          sum = {1'b0, phase_ms} + (TIMER_BITS + 1)'(s.elapsed_ms);
          phase_ms = (sum > {1'b0, PHASE_MAX}) ? PHASE_MAX : sum[TIMER_BITS-1:0];
          if (patrol_state == PATROL_WAIT && phase_ms > cfg_wait_ms) begin
            engage_state = ENG_PATROL;
            patrol_state = PATROL_RIGHT;
            phase_ms = '0;
          end else if (patrol_state == PATROL_RIGHT && phase_ms > cfg_spin_ms) begin
            patrol_state = PATROL_LEFT;
            phase_ms = '0;
          end else if (patrol_state == PATROL_LEFT && phase_ms > cfg_spin_ms) begin
            patrol_state = PATROL_RIGHT;
            phase_ms = '0;
          end
        end
        if (patrol_state == PATROL_WAIT) begin
          set_hold('0, '0, '0);
          mode = MODE_WAITING;
        end else if (patrol_state == PATROL_RIGHT) begin
          set_hold(cfg_spin_duty, cfg_spin_duty, LINE_E2 | LINE_E4);
          mode = MODE_SPIN_RIGHT;
        end else begin
          set_hold(cfg_spin_duty, cfg_spin_duty, LINE_E1 | LINE_E3);
          mode = MODE_SPIN_LEFT;
        end
      end
    end
    w.motor_one_duty = hold_one;
    w.motor_two_duty = hold_two;
    w.bridge_lines = hold_lines;
    w.mode_report = mode;
    // press then release toggles the enable, seen from the next sweep on
    if (s.button_level) begin
      button_down = 1'b1;
    end else if (button_down) begin
      button_down = 1'b0;
      allow_drive = !allow_drive;
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      errors++;
    end
  endtask

  task automatic check_drive_word(drive_t got);
    drive_t want;
    if (pending_drive_words.size() == 0) begin
      $display("%0t: drive word %h with nothing expected", $time, got);
      errors++;
    end else begin
      want = pending_drive_words.pop_front();
      compare_field("motor_one_duty", want.motor_one_duty, got.motor_one_duty);
      compare_field("motor_two_duty", want.motor_two_duty, got.motor_two_duty);
      compare_field("bridge_lines", want.bridge_lines, got.bridge_lines);
      compare_field("enabled", want.enabled, got.enabled);
      compare_field("mode_report", want.mode_report, got.mode_report);
      words_checked++;
    end
  endtask

  // sampled at the edge, so only pre-edge values are seen
  always @(posedge clk) begin
    if (rst_n && drive_if.valid && drive_if.ready) check_drive_word(drive_if.data);
  end

  // receiver: ready runs of random length, stalls between, now and then a long clear run
  initial begin : drive_stall_pattern
    bit rx_on;
    int rx_left;
    rx_on = 1'b0;
    rx_left = 0;
    drive_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_left == 0) begin
        rx_on = !rx_on;
        if (rx_on) rx_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 12);
        else rx_left = $urandom_range(1, 6);
      end
      rx_left--;
      drive_if.ready <= rx_on;
    end
  end

  // ---------------------------------------------------------------------------
  // sweep sender and register access
  // ---------------------------------------------------------------------------

  // valid stays high across a burst; after the burst it drops for a random gap
  task automatic send_sweep(sweep_t s);
    drive_t want;
    sweep_if.valid <= 1'b1;
    sweep_if.data <= s;
    do @(posedge clk); while (!sweep_if.ready);
    want = predict_drive(s);
    pending_drive_words.push_back(want);
    sweeps_sent++;
    mode_seen[want.mode_report]++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      sweep_if.valid <= 1'b0;
      // short gaps mostly, which land inside the block's own processing; now and then a long one
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(20, 50)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
      burst_left = ($urandom_range(0, 6) == 0) ? 30 : $urandom_range(0, 8);
    end
  endtask

  function automatic sweep_t sweep_of(int unsigned l, int unsigned c, int unsigned r,
                                      logic button, int unsigned ms);
    sweep_t s;
    s.echo_left_us = ECHO_BITS'(l);
    s.echo_centre_us = ECHO_BITS'(c);
    s.echo_right_us = ECHO_BITS'(r);
    s.button_level = button;
    s.elapsed_ms = MS_BITS'(ms);
    return s;
  endfunction

  // quiet the sender and let every outstanding sweep finish
  task automatic settle_idle();
    sweep_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_drive_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // setup then access phase for a write, the same for a read-back
  task automatic write_and_confirm(reg_idx_e idx, logic [APB_DATA_W-1:0] value, int width);
    logic [APB_DATA_W-1:0] mask;
    mask = (APB_DATA_W'(1) << width) - 1;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(int'(idx) * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) != (value & mask)) begin
      $display("%0t: register %s read expected %0d, got %0d", $time, idx.name(),
               value & mask, prdata & mask);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(int unsigned limit_cm, int unsigned spin, int unsigned wait_len,
                            int unsigned spin_len);
    settle_idle();
    write_and_confirm(REG_NEAR_LIMIT, limit_cm, LIMIT_BITS);
    write_and_confirm(REG_SPIN_DUTY, spin, DUTY_BITS);
    write_and_confirm(REG_WAIT_MS, wait_len, MS_BITS);
    write_and_confirm(REG_SPIN_MS, spin_len, MS_BITS);
    cfg_near_cm = LIMIT_BITS'(limit_cm);
    cfg_spin_duty = DUTY_BITS'(spin);
    cfg_wait_ms = MS_BITS'(wait_len);
    cfg_spin_ms = MS_BITS'(spin_len);
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // random content
  // ---------------------------------------------------------------------------

  // echo on the chosen side of the threshold, with the edges favoured
  function automatic int unsigned pick_echo(logic close);
    int unsigned th;
    th = int'(64'(cfg_near_cm) * CM_DEN / CM_NUM);
    if (close) begin
      case ($urandom_range(0, 5))
        0: return 0;
        1: return th;
        2: return $urandom_range(0, (th < 200) ? th : 200);
        default: return $urandom_range(0, th);
      endcase
    end
    case ($urandom_range(0, 5))
      0: return th + 1;
      1: return ECHO_TOP;
      2: return $urandom_range(th + 1, th + 2000);
      default: return $urandom_range(th + 1, ECHO_TOP);
    endcase
  endfunction

  function automatic int unsigned pick_elapsed();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return MS_TOP;
      2: return $urandom_range(0, 50);
      3: return $urandom_range(0, MS_TOP);
      default: return $urandom_range(0, 1200);
    endcase
  endfunction

  function automatic sweep_t make_sweep(logic [2:0] seen, logic button);
    return sweep_of(pick_echo(seen[2]), pick_echo(seen[1]), pick_echo(seen[0]), button,
                    pick_elapsed());
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // nothing seen before any engagement: held outputs from reset, idle mode
  task automatic test_idle_after_reset();
    send_sweep(sweep_of(ECHO_TOP, ECHO_TOP, ECHO_TOP, 1'b0, MS_TOP));
    send_sweep(sweep_of(5748, 5748, 5748, 1'b0, 0));
  endtask

  // every near pattern, duty extremes, timeout echoes and both soft-turn choices
  task automatic test_near_patterns();
    send_sweep(sweep_of(0, ECHO_TOP, ECHO_TOP, 1'b0, 10));     // timeout echo, pivot left
    send_sweep(sweep_of(100, 3000, ECHO_TOP, 1'b0, 20));       // soft left on left duty
    send_sweep(sweep_of(5747, 172, 9000, 1'b0, 30));           // soft left on centre duty
    send_sweep(sweep_of(ECHO_TOP, 5748, 5747, 1'b0, 40));      // pivot right at 99 cm
    send_sweep(sweep_of(8000, 173, 2000, 1'b0, 50));           // soft right on centre
    send_sweep(sweep_of(6000, 4000, 1, 1'b0, 60));             // soft right on right
    send_sweep(sweep_of(ECHO_TOP, 2500, ECHO_TOP, 1'b0, 70));  // straight
    send_sweep(sweep_of(10, ECHO_TOP, 20, 1'b0, 80));          // left and right: held
    send_sweep(sweep_of(0, 0, 0, 1'b0, 90));                   // all three: held
  endtask

  // wait, first spin right, swap to left; a hold pattern keeps patrol engagement
  task automatic test_patrol_cycle();
    send_sweep(sweep_of(ECHO_TOP, ECHO_TOP, ECHO_TOP, 1'b0, 500));  // enter waiting
    send_sweep(sweep_of(ECHO_TOP, ECHO_TOP, ECHO_TOP, 1'b0, 1000)); // exactly at limit
    send_sweep(sweep_of(ECHO_TOP, ECHO_TOP, ECHO_TOP, 1'b0, 0));
    send_sweep(sweep_of(ECHO_TOP, ECHO_TOP, ECHO_TOP, 1'b0, 1));    // past limit, spin right
    send_sweep(sweep_of(ECHO_TOP, ECHO_TOP, ECHO_TOP, 1'b0, MS_TOP)); // spin left
    send_sweep(sweep_of(ECHO_TOP, ECHO_TOP, ECHO_TOP, 1'b0, 1000));
    send_sweep(sweep_of(50, ECHO_TOP, 60, 1'b0, 5));                // patrol ends, held
    send_sweep(sweep_of(ECHO_TOP, ECHO_TOP, ECHO_TOP, 1'b0, 5));    // straight back to spin
  endtask

  // press and release toggles the enable on the following sweep
  task automatic test_button_toggle();
    send_sweep(sweep_of(ECHO_TOP, ECHO_TOP, ECHO_TOP, 1'b1, 200));
    send_sweep(sweep_of(ECHO_TOP, 300, ECHO_TOP, 1'b0, 0));         // release: disable next
    send_sweep(sweep_of(100, ECHO_TOP, ECHO_TOP, 1'b0, 0));         // motors stopped
    send_sweep(sweep_of(100, 100, 100, 1'b1, 0));
    send_sweep(sweep_of(ECHO_TOP, ECHO_TOP, ECHO_TOP, 1'b0, 0));    // release: enable next
    send_sweep(sweep_of(ECHO_TOP, ECHO_TOP, ECHO_TOP, 1'b0, 0));    // wait again
  endtask

  // widest and narrowest register settings, including 100 cm duty and zero times
  task automatic test_register_extremes();
    set_config(400, 255, 4000, 4000);
    send_sweep(sweep_of(ECHO_TOP, 5748, ECHO_TOP, 1'b0, 0));        // near, duty zero
    send_sweep(sweep_of(22988, 22989, 22989, 1'b0, 0));             // near at the limit
    send_sweep(sweep_of(22989, 22989, 22989, 1'b0, MS_TOP));
    set_config(0, 0, 0, 0);
    send_sweep(sweep_of(1, 1, 0, 1'b0, 0));                         // only zero is near
    send_sweep(sweep_of(1, 1, 1, 1'b0, 0));
    send_sweep(sweep_of(1, 1, 1, 1'b0, 0));                         // zero time not exceeded
    send_sweep(sweep_of(1, 1, 1, 1'b0, 1));
    send_sweep(sweep_of(1, 1, 1, 1'b0, 1));
  endtask

  // random phases under several settings; mostly engage-then-lose sequences
  task automatic test_random_sweeps();
    int sent;
    int runs;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_config(100, 128, 1000, 1000);
        1: set_config(400, 255, 4000, 4000);
        2: set_config(0, 0, 0, 0);
        default: set_config($urandom_range(0, 400), $urandom_range(0, 255),
                            $urandom_range(0, 4000), $urandom_range(0, 4000));
      endcase
      sent = 0;
      while (sent < PHASE_SWEEPS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            // tracking run over any near pattern
            runs = $urandom_range(1, 6);
            repeat (runs) send_sweep(make_sweep(3'($urandom_range(1, 7)), 1'b0));
          end
          5, 6, 7: begin
            // target lost: waiting and spinning
            runs = $urandom_range(1, 10);
            repeat (runs) send_sweep(make_sweep(SEE_NONE, 1'b0));
          end
          8: begin
            // disable, a few stopped sweeps, enable again
            runs = $urandom_range(1, 3);
            repeat (runs) send_sweep(make_sweep(3'($urandom_range(0, 7)), 1'b1));
            send_sweep(make_sweep(3'($urandom_range(0, 7)), 1'b0));
            repeat ($urandom_range(0, 3)) begin
              send_sweep(make_sweep(3'($urandom_range(0, 7)), 1'b0));
              runs++;
            end
            send_sweep(make_sweep(3'($urandom_range(0, 7)), 1'b1));
            send_sweep(make_sweep(3'($urandom_range(0, 7)), 1'b0));
            runs += 3;
          end
          default: begin
            // unshaped noise over the whole field ranges
            runs = $urandom_range(1, 3);
            repeat (runs) begin
              send_sweep(sweep_of($urandom_range(0, ECHO_TOP), $urandom_range(0, ECHO_TOP),
                                  $urandom_range(0, ECHO_TOP), 1'($urandom_range(0, 1)),
                                  $urandom_range(0, MS_TOP)));
            end
          end
        endcase
        sent += runs;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------

  initial begin
    sweep_if.valid <= 1'b0;
    sweep_if.data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst_n <= 1'b0;
    cfg_near_cm = NEAR_LIMIT_RESET;
    cfg_spin_duty = SPIN_DUTY_RESET;
    cfg_wait_ms = WAIT_MS_RESET;
    cfg_spin_ms = SPIN_MS_RESET;
    allow_drive = 1'b1;
    button_down = 1'b0;
    engage_state = ENG_NEVER;
    patrol_state = PATROL_OFF;
    phase_ms = '0;
    hold_one = '0;
    hold_two = '0;
    hold_lines = '0;
    errors = 0;
    sweeps_sent = 0;
    words_checked = 0;
    settings_used = 1;
    burst_left = 0;
    foreach (mode_seen[i]) mode_seen[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_after_reset();
    test_near_patterns();
    test_patrol_cycle();
    test_button_toggle();
    test_register_extremes();
    test_random_sweeps();
    settle_idle();

    $display("%0d sweeps sent, %0d drive words checked, %0d register settings",
             sweeps_sent, words_checked, settings_used);
    $display("modes: idle %0d, tracking %0d, waiting %0d, spin right %0d, spin left %0d",
             mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3], mode_seen[4]);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
